// ===== sv/clkfe_pkg.sv =====
// ----------------------------------------------------------------------------
// Clock field editor package
// Shared types, field limits, cursor positions, a month length helper and a wrap step helper.
// ----------------------------------------------------------------------------
`default_nettype none

package clkfe_pkg;

    typedef enum logic [1:0] {
        REQ_STEP   = 2'd0,
        REQ_BUTTON = 2'd1,
        REQ_LOAD   = 2'd2
    } t_req_kind;

    localparam logic [3:0] POS_HOUR    = 4'd0;
    localparam logic [3:0] POS_MINUTE  = 4'd1;
    localparam logic [3:0] POS_SECOND  = 4'd2;
    localparam logic [3:0] POS_DAY     = 4'd3;
    localparam logic [3:0] POS_MONTH   = 4'd4;
    localparam logic [3:0] POS_YEAR    = 4'd5;
    localparam logic [3:0] POS_WEEKDAY = 4'd6;
    localparam logic [3:0] POS_CONFIRM = 4'd7;
    localparam logic [3:0] POS_RUN     = 4'd8;

    localparam logic [6:0] HOUR_MAX    = 7'd23;
    localparam logic [6:0] MINUTE_MAX  = 7'd59;
    localparam logic [6:0] SECOND_MAX  = 7'd59;
    localparam logic [6:0] MONTH_MAX   = 7'd12;
    localparam logic [6:0] YEAR_MAX    = 7'd99;
    localparam logic [6:0] WEEKDAY_MAX = 7'd6;
    localparam logic [4:0] LONG_MONTH  = 5'd31;
    localparam logic [4:0] LEAP_FEB    = 5'd29;

    localparam logic [4:0] MONTH_DAYS [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic [1:0] req_type;
        logic       direction_up;
        logic [4:0] load_hour;
        logic [5:0] load_minute;
        logic [5:0] load_second;
        logic [4:0] load_day;
        logic [3:0] load_month;
        logic [6:0] load_year;
        logic [2:0] load_weekday;
    } t_req;

    typedef struct packed {
        logic [4:0] cur_hour;
        logic [5:0] cur_minute;
        logic [5:0] cur_second;
        logic [4:0] cur_day;
        logic [3:0] cur_month;
        logic [6:0] cur_year;
        logic [2:0] cur_weekday;
        logic       confirm_flag;
        logic [3:0] cursor_pos;
        logic       commit_pulse;
    } t_rsp;

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic [6:0] year);
        logic [4:0] len;
        if (month < 4'd1 || month > 4'd12) begin
            len = LONG_MONTH;
        end else if (month == 4'd2 && year[1:0] == 2'b00) begin
            len = LEAP_FEB;
        end else begin
            len = MONTH_DAYS[month - 4'd1];
        end
        return len;
    endfunction

    function automatic logic [6:0] wrap_step(input logic [6:0] v, input logic [6:0] lo,
                                             input logic [6:0] hi, input logic up);
        logic [6:0] res;
        if (up) begin
            res = (v < hi) ? v + 7'd1 : lo;
        end else begin
            res = (v > lo) ? v - 7'd1 : hi;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== sv/clkfe_if.sv =====
// ----------------------------------------------------------------------------
// Clock field editor channels
// Valid and ready channels for request words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface clkfe_req_if;
    import clkfe_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface clkfe_rsp_if;
    import clkfe_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/clock_field_editor.sv =====
// A request word waits in the input register; the update stage registers its result word.
// Throughput: one request word per cycle while no result word is stalled.
// A stalled result word holds the update stage, and the input register takes one more word.
// Reset: synchronous, active low; hour, minute, second, year and weekday clear to zero,
// day and month become 1, the confirm flag clears and the cursor sits at the run position.
// ----------------------------------------------------------------------------
// Clock field editor
// Date and time setting editor for an encoder and a select button.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_field_editor (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    clkfe_req_if.sink   i_req,
    clkfe_rsp_if.source o_rsp
);
    import clkfe_pkg::*;

    logic stage_valid;
    t_req stage_data;
    logic stage_take;

    clkfe_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_take  (stage_take),
        .o_valid (stage_valid),
        .o_data  (stage_data)
    );

    clkfe_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stage_valid),
        .i_data  (stage_data),
        .o_take  (stage_take),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

// ===== sv/clkfe_in_stage.sv =====
// ----------------------------------------------------------------------------
// Clock field editor input register
// Captures one request word and holds it until the update stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module clkfe_in_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    clkfe_req_if.sink          i_req,
    input  wire logic          i_take,
    output logic               o_valid,
    output clkfe_pkg::t_req    o_data
);
    import clkfe_pkg::*;

    logic r_valid;
    t_req r_data;

    assign i_req.ready = !r_valid || i_take;
    assign o_valid     = r_valid;
    assign o_data      = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_data <= i_req.data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/clkfe_core.sv =====
// ----------------------------------------------------------------------------
// Clock field editor update stage
// Holds the time fields, confirm flag and cursor; while no result word is
// stalled, applies one request word per cycle and registers the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module clkfe_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire clkfe_pkg::t_req i_data,
    output logic               o_take,
    clkfe_rsp_if.source        o_rsp
);
    import clkfe_pkg::*;

    logic [4:0] r_hour, n_hour;
    logic [5:0] r_minute, n_minute;
    logic [5:0] r_second, n_second;
    logic [4:0] r_day, n_day;
    logic [3:0] r_month, n_month;
    logic [6:0] r_year, n_year;
    logic [2:0] r_weekday, n_weekday;
    logic       r_confirm, n_confirm;
    logic [3:0] r_cursor, n_cursor;
    logic       n_commit;
    logic       r_out_valid;
    t_rsp       r_out;
    logic [4:0] day_max;
    logic [4:0] clamp_max;
    logic       advance;

    assign advance     = i_valid && (!r_out_valid || o_rsp.ready);
    assign o_take      = advance;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;
    assign day_max     = month_len(r_month, r_year);

    always_comb begin
        n_hour    = r_hour;
        n_minute  = r_minute;
        n_second  = r_second;
        n_day     = r_day;
        n_month   = r_month;
        n_year    = r_year;
        n_weekday = r_weekday;
        n_confirm = r_confirm;
        n_cursor  = r_cursor;
        n_commit  = 1'b0;
        clamp_max = LONG_MONTH;
        case (i_data.req_type)
            REQ_STEP: begin
                case (r_cursor)
                    POS_HOUR: n_hour = 5'(wrap_step(7'(r_hour), 7'd0, HOUR_MAX,
                                                    i_data.direction_up));
                    POS_MINUTE: n_minute = 6'(wrap_step(7'(r_minute), 7'd0, MINUTE_MAX,
                                                        i_data.direction_up));
                    POS_SECOND: n_second = 6'(wrap_step(7'(r_second), 7'd0, SECOND_MAX,
                                                        i_data.direction_up));
                    POS_DAY: n_day = 5'(wrap_step(7'(r_day), 7'd1, 7'(day_max),
                                                  i_data.direction_up));
                    POS_MONTH: n_month = 4'(wrap_step(7'(r_month), 7'd1, MONTH_MAX,
                                                      i_data.direction_up));
                    POS_YEAR: n_year = wrap_step(r_year, 7'd0, YEAR_MAX,
                                                 i_data.direction_up);
                    POS_WEEKDAY: n_weekday = 3'(wrap_step(7'(r_weekday), 7'd0, WEEKDAY_MAX,
                                                          i_data.direction_up));
                    POS_CONFIRM: n_confirm = i_data.direction_up;
                    default: begin
                    end
                endcase
                clamp_max = month_len(n_month, n_year);
                if (n_day > clamp_max) begin
                    n_day = clamp_max;
                end
            end
            REQ_BUTTON: begin
                n_commit = (r_cursor == POS_CONFIRM) && r_confirm;
                n_cursor = (r_cursor >= POS_RUN) ? POS_HOUR : r_cursor + 4'd1;
            end
            REQ_LOAD: begin
                if (r_cursor == POS_RUN) begin
                    n_hour    = i_data.load_hour;
                    n_minute  = i_data.load_minute;
                    n_second  = i_data.load_second;
                    n_day     = i_data.load_day;
                    n_month   = i_data.load_month;
                    n_year    = i_data.load_year;
                    n_weekday = i_data.load_weekday;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour      <= 5'd0;
            r_minute    <= 6'd0;
            r_second    <= 6'd0;
            r_day       <= 5'd1;
            r_month     <= 4'd1;
            r_year      <= 7'd0;
            r_weekday   <= 3'd0;
            r_confirm   <= 1'b0;
            r_cursor    <= POS_RUN;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_hour    <= n_hour;
                r_minute  <= n_minute;
                r_second  <= n_second;
                r_day     <= n_day;
                r_month   <= n_month;
                r_year    <= n_year;
                r_weekday <= n_weekday;
                r_confirm <= n_confirm;
                r_cursor  <= n_cursor;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.cur_hour     <= n_hour;
            r_out.cur_minute   <= n_minute;
            r_out.cur_second   <= n_second;
            r_out.cur_day      <= n_day;
            r_out.cur_month    <= n_month;
            r_out.cur_year     <= n_year;
            r_out.cur_weekday  <= n_weekday;
            r_out.confirm_flag <= n_confirm;
            r_out.cursor_pos   <= n_cursor;
            r_out.commit_pulse <= n_commit;
        end
    end

`ifndef SYNTHESIS
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= POS_RUN)
        else $error("cursor left its range");

    a_commit_at_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.commit_pulse |-> r_out.cursor_pos == POS_RUN)
        else $error("commit without return to run position");

    a_button_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && i_data.req_type == REQ_BUTTON && r_cursor != POS_RUN
        |=> r_cursor == $past(r_cursor) + 4'd1)
        else $error("button press did not advance the cursor");

    a_result_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out.cursor_pos == r_cursor && r_out.cur_day == r_day)
        else $error("result word does not match the stored state");
`endif

endmodule

`default_nettype wire
